/* sv/csc_pkg.sv */
// Shared types, constants and fixed-point coefficients of the current sensor conditioner.
package csc_pkg;

	// Block configuration (fixed by the sensor board)
	localparam int NCH      = 4;
	localparam int CHANNELS = 4;
	localparam int SAMPLES  = 16;
	localparam int WARMUP   = 500;
	localparam int CALIB    = 20;

	// Field and state widths
	localparam int CH_W   = 2;
	localparam int SMP_W  = 12;
	localparam int SUM_W  = 20;
	localparam int CNT_W  = 9;
	localparam int FILT_W = 20;
	localparam int OFF_W  = 12;
	localparam int RDG_W  = 10;
	localparam int CSUM_W = 25;
	localparam int MA_W   = 16;
	localparam int Q_FRAC = 8;

	// Stream widths
	localparam int IN_DW      = 16;
	localparam int OUT_FLD_W  = CH_W + MA_W + FILT_W + OFF_W;
	localparam int OUT_DW     = ((OUT_FLD_W + 7) / 8) * 8;
	localparam int OUT_PAD    = OUT_DW - OUT_FLD_W;
	localparam int OUT_USER_W = 2;

	// Zero-current offset after reset: 2.53 V
	localparam logic [OFF_W-1:0] OFFSET_RESET = 12'd3140;
	localparam longint OFF_MAX = (64'd1 << OFF_W) - 1;

	// Exponential filter: (19 * f + mean + 10) / 20, division by reciprocal
	localparam int FILT_DIV  = 20;
	localparam int FILT_KEEP = FILT_DIV - 1;
	localparam int FILT_RND  = FILT_DIV / 2;
	localparam int ACC_W     = 25;
	localparam int FILT_K    = 30;
	localparam longint FILT_M = ((64'd1 << FILT_K) + FILT_DIV - 1) / FILT_DIV;
	localparam int FILT_M_W  = $clog2(FILT_M + 1);
	localparam int FPROD_W   = ACC_W + FILT_M_W;

	// Offset mean: round(sum / (256 * CALIB)), as floor(((sum + half) >> 8) / CALIB)
	localparam int CAL_RND   = (256 * CALIB) / 2;
	localparam int CALN_W    = CSUM_W + 1;
	localparam int CALY_W    = CALN_W - Q_FRAC;
	localparam int CAL_K     = 23;
	localparam longint CAL_M = ((64'd1 << CAL_K) + CALIB - 1) / CALIB;
	localparam int CAL_M_W   = $clog2(CAL_M + 1);
	localparam int CPRODC_W  = CALY_W + CAL_M_W;

	// Milliamps: |diff| * 3300000 / (256 * 4096 * 185) = |diff| * 20625 / (37 * 2^15)
	localparam int CUR_NUM   = 20625;
	localparam int CUR_NUM_W = $clog2(CUR_NUM + 1);
	localparam int CUR_SH    = 15;
	localparam int CUR_DIV   = 37;
	localparam int CUR_K     = 26;
	localparam longint CUR_M = ((64'd1 << CUR_K) + CUR_DIV - 1) / CUR_DIV;
	localparam int CUR_M_W   = $clog2(CUR_M + 1);
	localparam int CPROD_W   = FILT_W + CUR_NUM_W;
	localparam int CURY_W    = CPROD_W - CUR_SH;
	localparam int QPROD_W   = CURY_W + CUR_M_W;
	localparam int CUR_MAX   = 17838;

	// Input beat kind
	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_CALIB  = 1'b1
	} cmd_t;

	// Completed reading handed from the front end to the scaling stages
	typedef struct packed {
		logic              valid;
		logic [CH_W-1:0]   ch;
		logic [FILT_W-1:0] filt;
		logic              active;
		logic              done;
		logic [CSUM_W-1:0] csum;
	} csc_rd_t;

endpackage

/* sv/csc_front.sv */
// Input register, per-channel averaging, exponential filter and calibration bookkeeping.
module csc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  take,
	input  csc_pkg::cmd_t         cmd,
	input  logic [csc_pkg::CH_W-1:0]  ch,
	input  logic [csc_pkg::SMP_W-1:0] smp,
	output csc_pkg::csc_rd_t      rd_s2
);
	import csc_pkg::*;

	logic              vld_s1;
	cmd_t              cmd_s1;
	logic [CH_W-1:0]   ch_s1;
	logic [SMP_W-1:0]  smp_s1;

	logic [SUM_W-1:0]  sum_q  [NCH];
	logic [CNT_W-1:0]  cnt_q  [NCH];
	logic [FILT_W-1:0] filt_q [NCH];
	logic              act_q  [NCH];
	logic [RDG_W-1:0]  rdg_q  [NCH];
	logic [CSUM_W-1:0] csum_q [NCH];

	logic              is_cal;
	logic              is_smp;
	logic [SUM_W-1:0]  sum_nx;
	logic [CNT_W-1:0]  cnt_nx;
	logic              full;
	logic [SUM_W+Q_FRAC-1:0] scaled;
	logic [FILT_W-1:0] mean;
	logic [ACC_W-1:0]  acc;
	logic [FPROD_W-1:0] fprod;
	logic [FILT_W-1:0] filt_nx;
	logic [CSUM_W-1:0] csum_add;
	logic [RDG_W-1:0]  rdg_nx;
	logic              fin;

	// Capture the accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (en && take) begin
			cmd_s1 <= cmd;
			ch_s1  <= ch;
			smp_s1 <= smp;
		end
	end

	// Accumulate, average and filter the selected channel
	always_comb begin
		is_cal = vld_s1 && (cmd_s1 == CMD_CALIB);
		is_smp = vld_s1 && (cmd_s1 == CMD_SAMPLE) &&
			({1'b0, ch_s1} < (CH_W+1)'(CHANNELS));
		sum_nx = sum_q[ch_s1] + SUM_W'(smp_s1);
		cnt_nx = cnt_q[ch_s1] + 1'b1;
		full   = cnt_nx >= CNT_W'(SAMPLES);
		scaled = {sum_nx, Q_FRAC'(0)};
		// power-of-two sample count: reduces to a shift
		mean   = FILT_W'(scaled / SAMPLES);
		acc    = ACC_W'(filt_q[ch_s1]) * ACC_W'(FILT_KEEP) + ACC_W'(mean) + ACC_W'(FILT_RND);
		fprod  = FPROD_W'(acc) * FPROD_W'(FILT_M);
		filt_nx = FILT_W'(fprod >> FILT_K);
		// calibration: skip warmup readings, then sum filtered codes
		csum_add = (rdg_q[ch_s1] >= RDG_W'(WARMUP)) ?
			csum_q[ch_s1] + CSUM_W'(filt_nx) : csum_q[ch_s1];
		rdg_nx = rdg_q[ch_s1] + 1'b1;
		fin    = act_q[ch_s1] && (rdg_nx >= RDG_W'(WARMUP + CALIB));
	end

	// Update channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++) begin
				sum_q[c]  <= '0;
				cnt_q[c]  <= '0;
				filt_q[c] <= '0;
				act_q[c]  <= 1'b0;
				rdg_q[c]  <= '0;
				csum_q[c] <= '0;
			end
		end else if (en) begin
			if (is_cal) begin
				for (int c = 0; c < NCH; c++) begin
					act_q[c]  <= 1'b1;
					rdg_q[c]  <= '0;
					csum_q[c] <= '0;
				end
			end else if (is_smp) begin
				if (full) begin
					sum_q[ch_s1]  <= '0;
					cnt_q[ch_s1]  <= '0;
					filt_q[ch_s1] <= filt_nx;
					if (act_q[ch_s1]) begin
						if (fin) begin
							act_q[ch_s1]  <= 1'b0;
							rdg_q[ch_s1]  <= '0;
							csum_q[ch_s1] <= '0;
						end else begin
							rdg_q[ch_s1]  <= rdg_nx;
							csum_q[ch_s1] <= csum_add;
						end
					end
				end else begin
					sum_q[ch_s1] <= sum_nx;
					cnt_q[ch_s1] <= cnt_nx;
				end
			end
		end
	end

	// Hand the completed reading on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s2 <= '0;
		end else if (en) begin
			rd_s2.valid  <= is_smp && full;
			rd_s2.ch     <= ch_s1;
			rd_s2.filt   <= filt_nx;
			rd_s2.active <= act_q[ch_s1] && !fin;
			rd_s2.done   <= fin;
			rd_s2.csum   <= csum_add;
		end
	end

endmodule

/* sv/current_sensor_conditioner.sv */
// Top level: offset apply and update, milliamp scaling, and the output skid buffer.
// The sample beat that completes a reading passes stages 1 to 4 and the output register.
// Throughput: one input beat per cycle; the four-stage pipeline holds only while the skid stage
// is full, and the output register holds its beat while m_tready is low.
// A calibrate beat or a sample that does not complete a reading gives no result beat.
// Asynchronous active-low reset clears all channel state and loads offsets with code 3140.
module current_sensor_conditioner (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [csc_pkg::IN_DW-1:0]    s_tdata,  // channel[1:0], sample[13:2]
	input  logic                         s_tuser,  // command[0]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [csc_pkg::OUT_DW-1:0]   m_tdata,  // channel_out[1:0], current_ma[17:2],
	                                               // filtered_code[37:18], offset_code[49:38]
	output logic [csc_pkg::OUT_USER_W-1:0] m_tuser // calibrating[0], calibration_done[1]
);
	import csc_pkg::*;

	typedef struct packed {
		logic              valid;
		logic [CH_W-1:0]   ch;
		logic [FILT_W-1:0] filt;
		logic [OFF_W-1:0]  off;
		logic              active;
		logic              done;
		logic              neg;
	} csc_res_t;

	logic               en;
	logic               take;
	csc_rd_t            rd_s2;

	logic [OFF_W-1:0]   off_q [NCH];
	logic [OFF_W-1:0]   off_sel;
	logic [FILT_W:0]    diff;
	logic [FILT_W:0]    ndiff;
	logic [FILT_W-1:0]  mag;
	logic [CALN_W-1:0]  cal_n;
	logic [CPRODC_W-1:0] cal_prod;
	logic [CPRODC_W-1:0] cal_q;
	logic [OFF_W-1:0]   new_off;

	csc_res_t           res_s3;
	logic [FILT_W-1:0]  mag_s3;
	csc_res_t           res_s4;
	logic [CPROD_W-1:0] prod_s4;

	logic [QPROD_W-1:0] qprod;
	logic [QPROD_W-1:0] q;
	logic [MA_W-1:0]    qs;
	logic [MA_W-1:0]    ma;
	logic [OUT_DW-1:0]  tdata_nx;
	logic [OUT_USER_W-1:0] tuser_nx;

	logic               m_vld_q;
	logic [OUT_DW-1:0]  m_tdata_q;
	logic [OUT_USER_W-1:0] m_tuser_q;
	logic               skid_vld_q;
	logic [OUT_DW-1:0]  skid_tdata_q;
	logic [OUT_USER_W-1:0] skid_tuser_q;

	// Advance the pipeline while the skid stage is free
	assign en       = !skid_vld_q;
	assign s_tready = en;
	assign take     = s_tvalid && s_tready;

	csc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.take   (take),
		.cmd    (cmd_t'(s_tuser)),
		.ch     (s_tdata[CH_W-1:0]),
		.smp    (s_tdata[CH_W+SMP_W-1:CH_W]),
		.rd_s2  (rd_s2)
	);

	// Offset difference and new offset from the calibration sum
	always_comb begin
		off_sel  = off_q[rd_s2.ch];
		diff     = {1'b0, rd_s2.filt} - {1'b0, off_sel, Q_FRAC'(0)};
		ndiff    = -diff;
		mag      = diff[FILT_W] ? ndiff[FILT_W-1:0] : diff[FILT_W-1:0];
		cal_n    = CALN_W'(rd_s2.csum) + CALN_W'(CAL_RND);
		cal_prod = CPRODC_W'(cal_n[CALN_W-1:Q_FRAC]) * CPRODC_W'(CAL_M);
		cal_q    = cal_prod >> CAL_K;
		new_off  = (cal_q > CPRODC_W'(OFF_MAX)) ? OFF_W'(OFF_MAX) : OFF_W'(cal_q);
	end

	// Hold offsets; load a new one when calibration finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++) begin
				off_q[c] <= OFFSET_RESET;
			end
		end else if (en && rd_s2.valid && rd_s2.done) begin
			off_q[rd_s2.ch] <= new_off;
		end
	end

	// Stage 3 and 4 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s3 <= '0;
			res_s4 <= '0;
		end else if (en) begin
			res_s3.valid  <= rd_s2.valid;
			res_s3.ch     <= rd_s2.ch;
			res_s3.filt   <= rd_s2.filt;
			res_s3.off    <= rd_s2.done ? new_off : off_sel;
			res_s3.active <= rd_s2.active;
			res_s3.done   <= rd_s2.done;
			res_s3.neg    <= diff[FILT_W];
			res_s4        <= res_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3  <= mag;
			prod_s4 <= CPROD_W'(mag_s3) * CPROD_W'(CUR_NUM);
		end
	end

	// Finish the division, saturate and restore the sign
	always_comb begin
		qprod = QPROD_W'(prod_s4[CPROD_W-1:CUR_SH]) * QPROD_W'(CUR_M);
		q     = qprod >> CUR_K;
		qs    = (q > QPROD_W'(CUR_MAX)) ? MA_W'(CUR_MAX) : MA_W'(q);
		ma    = res_s4.neg ? (~qs + 1'b1) : qs;
		tdata_nx = {{OUT_PAD{1'b0}}, res_s4.off, res_s4.filt, ma, res_s4.ch};
		tuser_nx = {res_s4.done, res_s4.active};
	end

	// Output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q    <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (m_tready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (res_s4.valid) begin
			if (m_vld_q && !m_tready) begin
				skid_vld_q <= 1'b1;
			end else begin
				m_vld_q <= 1'b1;
			end
		end else if (m_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (m_tready) begin
				m_tdata_q <= skid_tdata_q;
				m_tuser_q <= skid_tuser_q;
			end
		end else if (res_s4.valid) begin
			if (m_vld_q && !m_tready) begin
				skid_tdata_q <= tdata_nx;
				skid_tuser_q <= tuser_nx;
			end else begin
				m_tdata_q <= tdata_nx;
				m_tuser_q <= tuser_nx;
			end
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* sv/csc_checker.sv */
// Port-level checks on the result stream of the current sensor conditioner, and their binding.
module csc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [csc_pkg::OUT_DW-1:0]      m_tdata,
	input logic [csc_pkg::OUT_USER_W-1:0]  m_tuser
);
	import csc_pkg::*;

	localparam logic signed [MA_W-1:0] MA_LIM = MA_W'(CUR_MAX);

	// A stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// A finished calibration never reports itself as still running
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0])
		else $error("calibration done while still calibrating");

	// Current stays inside the saturation range
	a_ma_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[17:2]) <= MA_LIM) && ($signed(m_tdata[17:2]) >= -MA_LIM))
		else $error("current out of range");

	// Only served channels report
	a_chan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, m_tdata[1:0]} < (CH_W+1)'(CHANNELS)))
		else $error("result for an unserved channel");

endmodule

bind current_sensor_conditioner csc_checker u_csc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
